// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the gravity force block.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PGF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pgf assertion failed");

// Next-cycle implication, checked outside reset.
`define PGF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pgf assertion failed");

`endif

// ===== sv/pgf_pkg.sv =====
// Package of the pairwise gravity force block: widths, limits and pipeline side-band types.
// Depends on nothing; used by every module of the block.
`default_nettype none
package pgf_pkg;
	localparam int PosW     = 30;
	localparam int MagW     = 30;
	localparam int MassW    = 16;
	localparam int GravW    = 32;
	localparam int SqW      = 61;
	localparam int RootW    = 31;
	localparam int AccW     = 64;
	localparam int DenW     = 92;
	localparam int ProdW    = 94;
	localparam int ForceW   = 48;
	localparam int SqrtSteps = 32;
	localparam int SqrtW    = 64;

	localparam logic [ForceW-1:0] PosLimit = 48'h7FFF_FFFF_FFFF;
	localparam logic [ForceW-1:0] NegLimit = 48'h8000_0000_0000;

	typedef struct packed {
		logic [MagW-1:0] ax;
		logic [MagW-1:0] ay;
		logic            negx;
		logic            negy;
		logic            coin;
		logic [AccW-1:0] acc;
		logic [SqW-1:0]  sq;
	} sqrt_side_t;

	typedef struct packed {
		logic neg;
		logic coin;
	} div_tag_t;
endpackage
`default_nettype wire

// ===== sv/pairwise_gravity_force.sv =====
// Top level of the pairwise 2D gravity force pipeline.
// Depends on pgf_pkg, pgf_sqrt, pgf_div and assert_macros.svh.
//
// Channel   Ports                                                  Handshake
// input     self_x self_y self_mass other_x other_y other_mass     start, busy
// result    force_x force_y saturated coincident                   done (one-cycle strobe)
// config    gravity_constant                                        gravity_we
//
// An item is taken at every edge with start high; busy is always low, so one
// item enters per cycle. The item passes 87 register stages, most of them in the
// 32-stage square root and the 50-stage divider. Reset clears all valid bits and
// sets the gravity constant to 10.0. The receiver cannot stall, so the pipeline
// never holds.
`default_nettype none
module pairwise_gravity_force (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [pgf_pkg::PosW-1:0] self_x,
	input  wire logic signed [pgf_pkg::PosW-1:0] self_y,
	input  wire logic [pgf_pkg::MassW-1:0]     self_mass,
	input  wire logic signed [pgf_pkg::PosW-1:0] other_x,
	input  wire logic signed [pgf_pkg::PosW-1:0] other_y,
	input  wire logic [pgf_pkg::MassW-1:0]     other_mass,
	input  wire logic                          gravity_we,
	input  wire logic [pgf_pkg::GravW-1:0]     gravity_constant,
	output logic                               done,
	output logic signed [pgf_pkg::ForceW-1:0]  force_x,
	output logic signed [pgf_pkg::ForceW-1:0]  force_y,
	output logic                               saturated,
	output logic                               coincident
);
	localparam int DW = pgf_pkg::PosW + 1;

	assign busy = 1'b0;

	// Gravity constant register; the user writes only while the pipeline is empty, not enforced here.
	logic [pgf_pkg::GravW-1:0] grav_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 32'd655360;
		end else if (gravity_we) begin
			grav_q <= gravity_constant;
		end
	end

	// Stage 1: raw differences, their magnitudes and signs, the coincidence flag and the mass product.
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]        mx, my;
	assign dx = DW'(other_x) - DW'(self_x);
	assign dy = DW'(other_y) - DW'(self_y);
	assign mx = dx[DW-1] ? DW'(0) - dx : dx;
	assign my = dy[DW-1] ? DW'(0) - dy : dy;

	logic                         vld_s1;
	logic [pgf_pkg::MagW-1:0]     ax_s1, ay_s1;
	logic                         negx_s1, negy_s1, coin_s1;
	logic [2*pgf_pkg::MassW-1:0]  mm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1   <= mx[pgf_pkg::MagW-1:0];
		ay_s1   <= my[pgf_pkg::MagW-1:0];
		negx_s1 <= dx[DW-1];
		negy_s1 <= dy[DW-1];
		coin_s1 <= (dx == '0) && (dy == '0);
		mm_s1   <= 32'(self_mass) * 32'(other_mass);
	end

	// Stage 2: squared distance and G * m1 * m2.
	logic                vld_s2;
	pgf_pkg::sqrt_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2.ax   <= ax_s1;
		side_s2.ay   <= ay_s1;
		side_s2.negx <= negx_s1;
		side_s2.negy <= negy_s1;
		side_s2.coin <= coin_s1;
		side_s2.acc  <= 64'(grav_q) * 64'(mm_s1);
		side_s2.sq   <= 61'(60'(ax_s1) * 60'(ax_s1)) + 61'(60'(ay_s1) * 60'(ay_s1));
	end

	// Square root pipeline.
	logic                       sq_vld;
	pgf_pkg::sqrt_side_t        sq_side;
	logic [pgf_pkg::RootW-1:0]  root;

	pgf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_side   (side_s2),
		.out_valid (sq_vld),
		.out_side  (sq_side),
		.out_root  (root)
	);

	// Stage 3: partial products of s * r and of a * |d|, each no wider than 32 by 32.
	logic        vld_s3, negx_s3, negy_s3, coin_s3;
	logic [62:0] pden0_s3;
	logic [59:0] pden1_s3;
	logic [61:0] px0_s3, px1_s3, py0_s3, py1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		negx_s3  <= sq_side.negx;
		negy_s3  <= sq_side.negy;
		coin_s3  <= sq_side.coin;
		pden0_s3 <= 63'(sq_side.sq[31:0]) * 63'(root);
		pden1_s3 <= 60'(sq_side.sq[60:32]) * 60'(root);
		px0_s3   <= 62'(sq_side.acc[31:0]) * 62'(sq_side.ax);
		px1_s3   <= 62'(sq_side.acc[63:32]) * 62'(sq_side.ax);
		py0_s3   <= 62'(sq_side.acc[31:0]) * 62'(sq_side.ay);
		py1_s3   <= 62'(sq_side.acc[63:32]) * 62'(sq_side.ay);
	end

	// Stage 4: assemble the denominator and both numerators.
	logic                       vld_s4;
	pgf_pkg::div_tag_t          tagx_s4, tagy_s4;
	logic [pgf_pkg::DenW-1:0]   den_s4;
	logic [pgf_pkg::ProdW-1:0]  prodx_s4, prody_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tagx_s4  <= '{neg: negx_s3, coin: coin_s3};
		tagy_s4  <= '{neg: negy_s3, coin: coin_s3};
		den_s4   <= pgf_pkg::DenW'(pden0_s3) + (pgf_pkg::DenW'(pden1_s3) << 32);
		prodx_s4 <= pgf_pkg::ProdW'(px0_s3) + (pgf_pkg::ProdW'(px1_s3) << 32);
		prody_s4 <= pgf_pkg::ProdW'(py0_s3) + (pgf_pkg::ProdW'(py1_s3) << 32);
	end

	// Two dividers side by side, one for each component.
	logic                        dvx_vld, dvy_vld, satx, saty;
	pgf_pkg::div_tag_t           dvx_tag, dvy_tag;
	logic [pgf_pkg::ForceW-1:0]  fx, fy;

	pgf_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_tag    (tagx_s4),
		.in_prod   (prodx_s4),
		.in_den    (den_s4),
		.out_valid (dvx_vld),
		.out_tag   (dvx_tag),
		.out_force (fx),
		.out_sat   (satx)
	);

	pgf_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_tag    (tagy_s4),
		.in_prod   (prody_s4),
		.in_den    (den_s4),
		.out_valid (dvy_vld),
		.out_tag   (dvy_tag),
		.out_force (fy),
		.out_sat   (saty)
	);

	// Output register. Coincident bodies override whatever the divider made of a zero
	// denominator. The y tag carries the same coin flag as the x tag; its valid and coin are combined.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done       <= 1'b0;
			saturated  <= 1'b0;
			coincident <= 1'b0;
		end else begin
			done       <= dvx_vld && dvy_vld;
			saturated  <= dvx_vld && !dvx_tag.coin && (satx || saty);
			coincident <= dvx_vld && dvx_tag.coin && dvy_tag.coin;
		end
	end

	always_ff @(posedge clk) begin
		force_x <= dvx_tag.coin ? '0 : fx;
		force_y <= dvx_tag.coin ? '0 : fy;
	end

`include "assert_macros.svh"

	`PGF_ASSERT_IMPL(a_coin_zero, coincident, (force_x == '0) && (force_y == '0) && !saturated)
	`PGF_ASSERT_IMPL(a_flags_need_done, !done, !saturated && !coincident)
	`PGF_ASSERT_IMPL(a_done_from_start, done, $past(start, 87))
	`PGF_ASSERT_NEXT(a_enter_stage1, start, vld_s1)
endmodule
`default_nettype wire

// ===== sv/pgf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side-band that travels along.
// Depends on pgf_pkg.
`default_nettype none
module pgf_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire pgf_pkg::sqrt_side_t       in_side,
	output logic                           out_valid,
	output pgf_pkg::sqrt_side_t            out_side,
	output logic [pgf_pkg::RootW-1:0]      out_root
);
	logic                        vld_s  [0:pgf_pkg::SqrtSteps];
	logic [pgf_pkg::SqrtW-1:0]   rem_s  [0:pgf_pkg::SqrtSteps];
	logic [pgf_pkg::SqrtW-1:0]   res_s  [0:pgf_pkg::SqrtSteps];
	pgf_pkg::sqrt_side_t         side_s [0:pgf_pkg::SqrtSteps];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = pgf_pkg::SqrtW'(in_side.sq);
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < pgf_pkg::SqrtSteps; k++) begin : g_step
		localparam logic [pgf_pkg::SqrtW-1:0] StepBit =
			pgf_pkg::SqrtW'(1) << (2 * (pgf_pkg::SqrtSteps - 1 - k));
		logic [pgf_pkg::SqrtW-1:0] trial;
		logic                      take;

		assign trial = res_s[k] + StepBit;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
			res_s[k+1]  <= take ? (res_s[k] >> 1) + StepBit : res_s[k] >> 1;
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[pgf_pkg::SqrtSteps];
	assign out_side  = side_s[pgf_pkg::SqrtSteps];
	assign out_root  = res_s[pgf_pkg::SqrtSteps][pgf_pkg::RootW-1:0];
endmodule
`default_nettype wire

// ===== sv/pgf_div.sv =====
// Pipelined restoring divider for one force component, with overflow check and saturation.
// Depends on pgf_pkg.
`default_nettype none
module pgf_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire pgf_pkg::div_tag_t          in_tag,
	input  wire logic [pgf_pkg::ProdW-1:0]  in_prod,
	input  wire logic [pgf_pkg::DenW-1:0]   in_den,
	output logic                            out_valid,
	output pgf_pkg::div_tag_t               out_tag,
	output logic [pgf_pkg::ForceW-1:0]      out_force,
	output logic                            out_sat
);
	localparam int QW = pgf_pkg::ForceW;
	localparam int HiW = pgf_pkg::ProdW - 16;

	// The dividend is prod * 2^32; its top part is compared against den once, then
	// 48 quotient bits are developed one per stage.
	logic                        vld_s  [1:QW+1];
	pgf_pkg::div_tag_t           tag_s  [1:QW+1];
	logic                        ovf_s  [1:QW+1];
	logic [pgf_pkg::DenW-1:0]    den_s  [1:QW+1];
	logic [pgf_pkg::DenW-1:0]    rem_s  [1:QW+1];
	logic [QW-1:0]               low_s  [1:QW+1];
	logic [QW-1:0]               quo_s  [1:QW+1];

	logic [HiW-1:0] hi_part;
	assign hi_part = in_prod[pgf_pkg::ProdW-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else begin
			vld_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s[1] <= in_tag;
		ovf_s[1] <= pgf_pkg::DenW'(hi_part) >= in_den;
		den_s[1] <= in_den;
		rem_s[1] <= pgf_pkg::DenW'(hi_part);
		low_s[1] <= {in_prod[15:0], 32'd0};
		quo_s[1] <= '0;
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [pgf_pkg::DenW:0] cand;
		logic [pgf_pkg::DenW:0] diff;
		logic                   take;

		assign cand = {rem_s[j], low_s[j][QW-1]};
		assign diff = cand - {1'b0, den_s[j]};
		assign take = cand >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[j+1] <= tag_s[j];
			ovf_s[j+1] <= ovf_s[j];
			den_s[j+1] <= den_s[j];
			rem_s[j+1] <= take ? diff[pgf_pkg::DenW-1:0] : cand[pgf_pkg::DenW-1:0];
			low_s[j+1] <= low_s[j] << 1;
			quo_s[j+1] <= {quo_s[j][QW-2:0], take};
		end
	end

	logic [QW-1:0] limit;
	logic          clip;
	logic [QW-1:0] mag;

	always_comb begin
		limit = tag_s[QW+1].neg ? pgf_pkg::NegLimit : pgf_pkg::PosLimit;
		clip  = ovf_s[QW+1] || (quo_s[QW+1] > limit);
		mag   = clip ? limit : quo_s[QW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[QW+1];
		end
	end

	always_ff @(posedge clk) begin
		out_tag   <= tag_s[QW+1];
		out_sat   <= clip;
		out_force <= tag_s[QW+1].neg ? QW'(0) - mag : mag;
	end
endmodule
`default_nettype wire

// ===== tb/pairwise_gravity_force_tb.sv =====
// Self-checking testbench for the pairwise 2D gravity force pipeline.
// Depends on pgf_pkg and the pairwise_gravity_force RTL; reads no files.
`timescale 1ns / 100ps
`default_nettype none
module pairwise_gravity_force_tb;

	// One expected force result.
	typedef struct {
		logic [pgf_pkg::ForceW-1:0] fx;
		logic [pgf_pkg::ForceW-1:0] fy;
		logic                       sat;
		logic                       coin;
	} force_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [pgf_pkg::PosW-1:0]     self_x, self_y, other_x, other_y;
	logic [pgf_pkg::MassW-1:0]           self_mass, other_mass;
	logic                                gravity_we;
	logic [pgf_pkg::GravW-1:0]           gravity_constant;
	logic                                done;
	logic signed [pgf_pkg::ForceW-1:0]   force_x, force_y;
	logic                                saturated, coincident;

	// Copy of the gravity constant that the predictor uses.
	logic [pgf_pkg::GravW-1:0] grav_copy;
	force_t                    pending_forces[$];
	int                        mismatches;
	int                        quiet_cycles;
	bit                        steady;

	localparam int QuietLimit = 3000;

	pairwise_gravity_force u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.self_x(self_x), .self_y(self_y), .self_mass(self_mass),
		.other_x(other_x), .other_y(other_y), .other_mass(other_mass),
		.gravity_we(gravity_we), .gravity_constant(gravity_constant),
		.done(done), .force_x(force_x), .force_y(force_y),
		.saturated(saturated), .coincident(coincident)
	);

	always #4 clk = ~clk;

	// Integer square root, floor, of a sum of squares below 2^61.
	function automatic logic [63:0] int_sqrt(logic [63:0] s);
		logic [63:0] root, trial;
		root = '0;
		for (int i = 30; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= s) begin
				root = trial;
			end
		end
		return root;
	endfunction

	// One force component: magnitude a*|d|*2^32/(s*r), truncated, clipped to 48 bits.
	function automatic logic [pgf_pkg::ForceW-1:0] force_component(logic [63:0] a, longint d,
			logic [127:0] den, ref logic sat);
		logic [127:0] num, q, limit;
		logic [63:0]  mag;
		logic         neg;
		neg = d < 0;
		mag = neg ? -d : d;
		limit = neg ? 128'(pgf_pkg::NegLimit) : 128'(pgf_pkg::PosLimit);
		num = (128'(a) * 128'(mag)) << 32;
		q = num / den;
		if (q > limit) begin
			sat = 1'b1;
			q = limit;
		end
		return neg ? -q[pgf_pkg::ForceW-1:0] : q[pgf_pkg::ForceW-1:0];
	endfunction

	function automatic force_t predict_force(logic signed [pgf_pkg::PosW-1:0] sx,
			logic signed [pgf_pkg::PosW-1:0] sy, logic [pgf_pkg::MassW-1:0] sm,
			logic signed [pgf_pkg::PosW-1:0] ox, logic signed [pgf_pkg::PosW-1:0] oy,
			logic [pgf_pkg::MassW-1:0] om, logic [pgf_pkg::GravW-1:0] g);
		force_t       f;
		longint       dx, dy;
		logic [63:0]  ax, ay, s, a;
		logic [127:0] den;
		logic         sat;
		dx = longint'(ox) - longint'(sx);
		dy = longint'(oy) - longint'(sy);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		s = ax * ax + ay * ay;
		sat = 1'b0;
		if (s == 0) begin
			f.fx = '0;
			f.fy = '0;
			f.sat = 1'b0;
			f.coin = 1'b1;
			return f;
		end
		den = 128'(s) * 128'(int_sqrt(s));
		a = 64'(g) * 64'(sm) * 64'(om);
		f.fx = force_component(a, dx, den, sat);
		f.fy = force_component(a, dy, den, sat);
		f.sat = sat;
		f.coin = 1'b0;
		return f;
	endfunction

	// Monitor: predicts each accepted item and checks each result against the oldest
	// prediction. It also runs the watchdog on cycles where nothing moves.
	always @(posedge clk) begin
		force_t want;
		if (arst_n) begin
			if (start && !busy) begin
				pending_forces.push_back(predict_force(self_x, self_y, self_mass,
					other_x, other_y, other_mass, grav_copy));
			end
			if (done) begin
				if (pending_forces.size() == 0) begin
					$display("%0t: result with no item pending: fx=%h fy=%h", $time,
						force_x, force_y);
					mismatches++;
				end else begin
					want = pending_forces.pop_front();
					if (force_x !== want.fx) begin
						$display("%0t: force_x expected %h actual %h", $time, want.fx, force_x);
						mismatches++;
					end
					if (force_y !== want.fy) begin
						$display("%0t: force_y expected %h actual %h", $time, want.fy, force_y);
						mismatches++;
					end
					if (saturated !== want.sat) begin
						$display("%0t: saturated expected %b actual %b", $time, want.sat,
							saturated);
						mismatches++;
					end
					if (coincident !== want.coin) begin
						$display("%0t: coincident expected %b actual %b", $time, want.coin,
							coincident);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: watchdog expired with %0d results outstanding", $time,
					pending_forces.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Presents one body pair and holds it until the pipeline takes it. Acceptance is
	// judged from busy as seen at the falling edge, when it is settled.
	task automatic send_pair(logic signed [pgf_pkg::PosW-1:0] sx,
			logic signed [pgf_pkg::PosW-1:0] sy, logic [pgf_pkg::MassW-1:0] sm,
			logic signed [pgf_pkg::PosW-1:0] ox, logic signed [pgf_pkg::PosW-1:0] oy,
			logic [pgf_pkg::MassW-1:0] om);
		logic was_busy;
		if (!steady && $urandom_range(99) < 24) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		self_x <= sx;
		self_y <= sy;
		self_mass <= sm;
		other_x <= ox;
		other_y <= oy;
		other_mass <= om;
		start <= 1'b1;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
	endtask

	// Stops sending and waits until every predicted result has come back, then lets
	// the pipeline empty fully.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_forces.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_gravity(logic [pgf_pkg::GravW-1:0] value);
		drain_pipeline();
		gravity_we <= 1'b1;
		gravity_constant <= value;
		@(posedge clk);
		gravity_we <= 1'b0;
		grav_copy = value;
	endtask

	// Random position over the full 30-bit pattern space.
	function automatic logic signed [pgf_pkg::PosW-1:0] any_pos();
		return pgf_pkg::PosW'($urandom());
	endfunction

	// Attracting body placed near the acted-on one at a random scale, so that both
	// saturated and in-range forces are common.
	function automatic logic signed [pgf_pkg::PosW-1:0] near_pos(
			logic signed [pgf_pkg::PosW-1:0] p);
		int unsigned span;
		span = 1 << $urandom_range(0, 24);
		return $urandom_range(1) ? pgf_pkg::PosW'(p + $urandom_range(span))
			: pgf_pkg::PosW'(p - $urandom_range(span));
	endfunction

	task automatic test_directed();
		logic signed [pgf_pkg::PosW-1:0] pmax, pmin;
		pmax = {1'b0, {(pgf_pkg::PosW-1){1'b1}}};
		pmin = {1'b1, {(pgf_pkg::PosW-1){1'b0}}};
		// Extremes of the position range, in both orders and on both axes.
		send_pair(pmin, pmin, 16'hFFFF, pmax, pmax, 16'hFFFF);
		send_pair(pmax, pmax, 16'hFFFF, pmin, pmin, 16'hFFFF);
		send_pair(pmax, 0, 1, pmin, 0, 1);
		send_pair(0, pmin, 1, 0, pmax, 1);
		// Coincident bodies, including at the extremes and with zero mass.
		send_pair(0, 0, 16'hFFFF, 0, 0, 16'hFFFF);
		send_pair(pmax, pmin, 5, pmax, pmin, 7);
		send_pair(12345, -777, 0, 12345, -777, 0);
		// Zero mass on either side gives zero force without a flag.
		send_pair(0, 0, 0, 65536, 0, 16'hFFFF);
		send_pair(0, 0, 16'hFFFF, 0, -65536, 0);
		// Unit distance with heavy bodies saturates; sign follows the offset.
		send_pair(0, 0, 16'hFFFF, 1, 0, 16'hFFFF);
		send_pair(0, 0, 16'hFFFF, -1, 0, 16'hFFFF);
		send_pair(0, 0, 16'hFFFF, 0, 1, 16'hFFFF);
		send_pair(0, 0, 16'hFFFF, 1, -1, 16'hFFFF);
		// Modest distances in each quadrant that stay in range.
		send_pair(0, 0, 3, 65536 * 4, 65536 * 3, 2);
		send_pair(0, 0, 3, -65536 * 4, 65536 * 3, 2);
		send_pair(0, 0, 3, -65536 * 4, -65536 * 3, 2);
		send_pair(0, 0, 3, 65536 * 4, -65536 * 3, 2);
		send_pair(-100, 50, 1, 1000, -2000, 1);
		drain_pipeline();
	endtask

	// Runs the same pairs under extreme and ordinary gravity settings, zero included.
	task automatic test_gravity_settings();
		logic [pgf_pkg::GravW-1:0] settings[4];
		settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd655360};
		foreach (settings[k]) begin
			write_gravity(settings[k]);
			send_pair(0, 0, 16'hFFFF, 65536, 65536, 16'hFFFF);
			send_pair(0, 0, 1, 65536 * 1000, 0, 1);
			send_pair(0, 0, 16'hFFFF, 3, -4, 16'hFFFF);
		end
		drain_pipeline();
	endtask

	task automatic test_random_pairs();
		logic signed [pgf_pkg::PosW-1:0] sx, sy, ox, oy;
		logic [pgf_pkg::MassW-1:0]       sm, om;
		logic [pgf_pkg::GravW-1:0]       g;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: g = 32'd655360;
				1: g = $urandom_range(1, 65536);
				2: g = $urandom();
				default: g = $urandom_range(1, 255);
			endcase
			write_gravity(g);
			for (int n = 0; n < 455; n++) begin
				steady = (phase == 1) && (n >= 100) && (n < 300);
				sx = any_pos();
				sy = any_pos();
				sm = $urandom_range(1) ? pgf_pkg::MassW'($urandom())
					: pgf_pkg::MassW'($urandom_range(0, 15));
				om = $urandom_range(1) ? pgf_pkg::MassW'($urandom())
					: pgf_pkg::MassW'($urandom_range(0, 15));
				case ($urandom_range(9))
					0, 1: begin
						ox = any_pos();
						oy = any_pos();
					end
					2: begin
						ox = sx;
						oy = $urandom_range(1) ? sy : near_pos(sy);
					end
					default: begin
						ox = near_pos(sx);
						oy = near_pos(sy);
					end
				endcase
				send_pair(sx, sy, sm, ox, oy, om);
			end
			steady = 1'b0;
		end
		drain_pipeline();
	endtask

	initial begin
		arst_n = 1'b0;
		start <= 1'b0;
		self_x <= '0;
		self_y <= '0;
		self_mass <= '0;
		other_x <= '0;
		other_y <= '0;
		other_mass <= '0;
		gravity_we <= 1'b0;
		gravity_constant <= '0;
		grav_copy = 32'd655360;
		mismatches = 0;
		quiet_cycles = 0;
		steady = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_gravity_settings();
		test_random_pairs();

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
